// ===== rtl/htp_pkg.sv =====
// Package for the two-probe hash table: field widths, operation codes and
// the controller state type. Depends on nothing; every rtl file imports it.

package htp_pkg;

	// Fixed widths of the channel fields.
	localparam int KEY_W  = 16;
	localparam int VAL_W  = 32;
	localparam int MODE_W = 2;
	localparam int RANK_W = 7;
	localparam int SLOT_W = 6;

	// Width of the fractional hash digit, (43 * key) mod 100.
	localparam int FRAC_W = 7;

	// Operation carried by the mode field of an input beat.
	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT = 2'd0,
		MODE_DELETE = 2'd1,
		MODE_LOOKUP = 2'd2,
		MODE_RANK   = 2'd3
	} mode_t;

	// Controller states of the table sequencer.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_RD_S,
		ST_CHK_S,
		ST_SCAN,
		ST_RESP
	} state_t;

endpackage

// ===== rtl/hash_table_two_probe.sv =====
// Top level of the two-probe hash table: sequencer, slot memory and result
// register. Depends on htp_pkg and instantiates htp_hash.
//
//   channel  signals                          direction  beat
//   input    mode, key, value, rank           in         in_valid & in_ready
//   result   found, slot, found_key,          out        out_valid & out_ready
//            found_value
//
// Insert goes through the 3 hash stages, a read of the primary slot with the
// write, a response step and an idle step before the next accept; delete and
// lookup also read the secondary slot on a primary miss. The slot memory has
// one write and one registered read port. Rank mode walks the memory one slot
// per cycle. After reset a clearing pass empties every slot; in_ready stays
// low meanwhile. A stalled result holds in the output register while the
// next beat is accepted; it stalls only the response step.

module hash_table_two_probe import htp_pkg::*; #(
	parameter int TABLE_SIZE = 64,
	parameter int VALUE_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [MODE_W-1:0] mode,
	input  logic [KEY_W-1:0]  key,
	input  logic [VAL_W-1:0]  value,
	input  logic [RANK_W-1:0] rank,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              found,
	output logic [SLOT_W-1:0] slot,
	output logic [KEY_W-1:0]  found_key,
	output logic [VAL_W-1:0]  found_value
);

	localparam int IW  = $clog2(TABLE_SIZE);
	localparam int EW  = KEY_W + VALUE_BITS;
	localparam int CW  = $clog2(TABLE_SIZE + 1);
	localparam int CMW = (CW > RANK_W) ? CW : RANK_W;
	localparam int OVW = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;
	localparam logic [IW-1:0] LAST = IW'(TABLE_SIZE - 1);

	state_t state_q, state_d;

	// Slot memory: key in the upper bits, value in the lower bits.
	logic [EW-1:0] mem [TABLE_SIZE];
	logic [EW-1:0] rd_q;
	logic          mem_we;
	logic [IW-1:0] mem_wa;
	logic [IW-1:0] mem_ra;
	logic [EW-1:0] mem_wd;
	logic [KEY_W-1:0]      rd_key;
	logic [VALUE_BITS-1:0] rd_val;

	// Captured beat and hash results.
	mode_t                 mode_q;
	logic [KEY_W-1:0]      key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [RANK_W-1:0]     rank_q;
	logic [IW-1:0]         prim_q;
	logic [IW-1:0]         sec_q;

	// Clearing and scan walk.
	logic [IW-1:0] ptr_q;
	logic [IW-1:0] ptr_nx;
	logic [CW-1:0] cnt_q;
	logic          scan_vld_s1;
	logic [IW-1:0] scan_addr_s1;
	logic          rank_hit;

	// Pending result.
	logic                  res_ld;
	logic                  res_hit;
	logic [IW-1:0]         res_idx;
	logic [KEY_W-1:0]      res_key;
	logic [VALUE_BITS-1:0] res_val;
	logic                  res_found_q;
	logic [IW-1:0]         res_slot_q;
	logic [KEY_W-1:0]      res_key_q;
	logic [VALUE_BITS-1:0] res_val_q;

	// Output register.
	logic              out_valid_q;
	logic              out_free;
	logic              found_q;
	logic [SLOT_W-1:0] slot_q;
	logic [KEY_W-1:0]  found_key_q;
	logic [VAL_W-1:0]  found_value_q;

	logic          accept;
	logic          hash_start;
	logic          hash_done;
	logic [IW-1:0] hash_prim;
	logic [IW-1:0] hash_sec;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign hash_start = accept && (mode_t'(mode) != MODE_RANK) && (key != '0);
	assign out_free   = !out_valid_q || out_ready;

	assign rd_key   = rd_q[EW-1 -: KEY_W];
	assign rd_val   = rd_q[VALUE_BITS-1:0];
	assign ptr_nx   = (ptr_q == LAST) ? '0 : ptr_q + 1'b1;
	assign rank_hit = (CMW'(cnt_q) + CMW'(1)) == CMW'(rank_q);

	htp_hash #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_hash (
		.clk   (clk),
		.arst_n(arst_n),
		.start (hash_start),
		.key   (key),
		.done  (hash_done),
		.prim  (hash_prim),
		.sec   (hash_sec)
	);

	// Slot memory with one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[mem_ra];
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, memory access and result selection.
	always_comb begin
		state_d = state_q;
		mem_we  = 1'b0;
		mem_wa  = ptr_q;
		mem_wd  = '0;
		mem_ra  = ptr_q;
		res_ld  = 1'b0;
		res_hit = 1'b0;
		res_idx = '0;
		res_key = '0;
		res_val = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (ptr_q == LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					if (mode_t'(mode) == MODE_RANK) begin
						if (rank == '0) begin
							res_ld  = 1'b1;
							state_d = ST_RESP;
						end else begin
							state_d = ST_SCAN;
						end
					end else if (key == '0) begin
						res_ld  = 1'b1;
						state_d = ST_RESP;
					end else begin
						state_d = ST_HASH;
					end
				end
			end
			ST_HASH: begin
				mem_ra = hash_prim;
				if (hash_done) begin
					state_d = ST_RD_S;
				end
			end
			ST_RD_S: begin
				// Read data holds the primary slot.
				mem_ra = sec_q;
				if (mode_q == MODE_INSERT) begin
					mem_we  = 1'b1;
					mem_wa  = (rd_key == '0) ? prim_q : sec_q;
					mem_wd  = {key_q, val_q};
					res_ld  = 1'b1;
					res_hit = 1'b1;
					res_idx = mem_wa;
					res_key = key_q;
					res_val = val_q;
					state_d = ST_RESP;
				end else if (rd_key == key_q) begin
					mem_we  = (mode_q == MODE_DELETE);
					mem_wa  = prim_q;
					res_ld  = 1'b1;
					res_hit = 1'b1;
					res_idx = prim_q;
					res_key = rd_key;
					res_val = rd_val;
					state_d = ST_RESP;
				end else begin
					state_d = ST_CHK_S;
				end
			end
			ST_CHK_S: begin
				// Read data holds the secondary slot.
				res_ld  = 1'b1;
				state_d = ST_RESP;
				if (rd_key == key_q) begin
					mem_we  = (mode_q == MODE_DELETE);
					mem_wa  = sec_q;
					res_hit = 1'b1;
					res_idx = sec_q;
					res_key = rd_key;
					res_val = rd_val;
				end
			end
			ST_SCAN: begin
				if (scan_vld_s1 && (rd_key != '0) && rank_hit) begin
					res_ld  = 1'b1;
					res_hit = 1'b1;
					res_idx = scan_addr_s1;
					res_key = rd_key;
					res_val = rd_val;
					state_d = ST_RESP;
				end else if (scan_vld_s1 && (scan_addr_s1 == LAST)) begin
					res_ld  = 1'b1;
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Walk pointer, occupied-slot count and scan read tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			cnt_q       <= '0;
			scan_vld_s1 <= 1'b0;
		end else begin
			scan_vld_s1 <= (state_q == ST_SCAN);
			if (state_q == ST_IDLE) begin
				ptr_q <= '0;
				cnt_q <= '0;
			end else if (state_q == ST_CLEAR || state_q == ST_SCAN) begin
				ptr_q <= ptr_nx;
			end
			if (state_q == ST_SCAN && scan_vld_s1 && rd_key != '0) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Beat capture, hash results and pending result.
	always_ff @(posedge clk) begin
		scan_addr_s1 <= ptr_q;
		if (accept) begin
			mode_q <= mode_t'(mode);
			key_q  <= key;
			val_q  <= VALUE_BITS'(value);
			rank_q <= rank;
		end
		if (state_q == ST_HASH && hash_done) begin
			prim_q <= hash_prim;
			sec_q  <= hash_sec;
		end
		if (res_ld) begin
			res_found_q <= res_hit;
			res_slot_q  <= res_idx;
			res_key_q   <= res_key;
			res_val_q   <= res_val;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_RESP && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (state_q == ST_RESP && out_free) begin
			found_q       <= res_found_q;
			slot_q        <= SLOT_W'(res_slot_q);
			found_key_q   <= res_key_q;
			found_value_q <= VAL_W'(res_val_q[OVW-1:0]);
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign slot        = slot_q;
	assign found_key   = found_key_q;
	assign found_value = found_value_q;

`ifndef ASSERT_OFF
	// A hit always names an occupied slot, and a miss never carries a key.
	a_found_key: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (found == (found_key != '0)))
		else $error("found flag disagrees with the returned key");

	// A miss beat returns an all-zero slot and value.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (slot == '0 && found_value == '0))
		else $error("miss beat carries a slot or value");

	// The memory is written only by the clearing pass or a probe decision.
	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_CLEAR || state_q == ST_RD_S || state_q == ST_CHK_S))
		else $error("slot memory written outside a write state");

	// Hash results arrive only while the sequencer waits for them.
	a_hash_wait: assert property (@(posedge clk) disable iff (!arst_n)
		hash_done |-> (state_q == ST_HASH))
		else $error("hash result arrived outside the hash wait");

	// The rank walk never counts past the requested rank.
	a_scan_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (CMW'(cnt_q) < CMW'(rank_q)))
		else $error("occupied-slot count passed the requested rank");
`endif

endmodule

// ===== rtl/htp_hash.sv =====
// Three-stage pipeline that turns a key into its primary and secondary
// table slots. Depends on htp_pkg for the key and fraction widths.

module htp_hash import htp_pkg::*; #(
	parameter int TABLE_SIZE = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [KEY_W-1:0]              key,
	output logic                          done,
	output logic [$clog2(TABLE_SIZE)-1:0] prim,
	output logic [$clog2(TABLE_SIZE)-1:0] sec
);

	localparam int IW = $clog2(TABLE_SIZE);

	// Reciprocal for floor((43 * key) / 100); exact over the whole key range.
	localparam int XW1 = $clog2(43 * (2 ** KEY_W));
	localparam int S1 = XW1 + 7;
	localparam longint unsigned M1 = ((64'd1 << S1) + 64'd99) / 64'd100;
	localparam longint unsigned K1 = 64'd43 * M1;
	localparam int K1W = $clog2(K1 + 64'd1);
	localparam int Q1W = $clog2((64'd1 << XW1) / 64'd100 + 64'd1);

	// Reciprocal for floor((13 * key) / TABLE_SIZE).
	localparam int XW2 = $clog2(13 * (2 ** KEY_W));
	localparam int S2 = XW2 + $clog2(TABLE_SIZE);
	localparam longint unsigned M2 =
		((64'd1 << S2) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
	localparam longint unsigned K2 = 64'd13 * M2;
	localparam int K2W = $clog2(K2 + 64'd1);
	localparam int Q2W = $clog2((64'd1 << XW2) / 64'(TABLE_SIZE) + 64'd1);

	// Scaled reciprocal for floor(frac * TABLE_SIZE / 100) in one product.
	localparam int YW = $clog2(99 * TABLE_SIZE + 1);
	localparam int S3 = YW + 7;
	localparam longint unsigned M3 = ((64'd1 << S3) + 64'd99) / 64'd100;
	localparam longint unsigned K3 = 64'(TABLE_SIZE) * M3;
	localparam int K3W = $clog2(K3 + 64'd1);

	logic [KEY_W+K1W-1:0]  p1_c;
	logic [KEY_W+K2W-1:0]  p2_c;
	logic [FRAC_W+K3W-1:0] p3_c;

	logic              v_s1, v_s2, v_s3;
	logic [XW1-1:0]    x43_s1;
	logic [Q1W-1:0]    q1_s1;
	logic [XW2-1:0]    x13_s1;
	logic [Q2W-1:0]    q2_s1;
	logic [FRAC_W-1:0] frac_s2;
	logic [IW-1:0]     sec_s2;
	logic [IW-1:0]     prim_s3;
	logic [IW-1:0]     sec_s3;

	// Quotient estimates by reciprocal multiplication.
	assign p1_c = (KEY_W+K1W)'(key) * (KEY_W+K1W)'(K1);
	assign p2_c = (KEY_W+K2W)'(key) * (KEY_W+K2W)'(K2);
	assign p3_c = (FRAC_W+K3W)'(frac_s2) * (FRAC_W+K3W)'(K3);

	// Valid bits follow the beat through the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: products and quotients; stage 2: remainders; stage 3: scaling.
	always_ff @(posedge clk) begin
		x43_s1  <= XW1'(key) * XW1'(43);
		q1_s1   <= Q1W'(p1_c >> S1);
		x13_s1  <= XW2'(key) * XW2'(13);
		q2_s1   <= Q2W'(p2_c >> S2);
		frac_s2 <= FRAC_W'(x43_s1 - XW1'(q1_s1) * XW1'(100));
		sec_s2  <= IW'(x13_s1 - XW2'(q2_s1) * XW2'(TABLE_SIZE));
		prim_s3 <= IW'(p3_c >> S3);
		sec_s3  <= sec_s2;
	end

	assign done = v_s3;
	assign prim = prim_s3;
	assign sec  = sec_s3;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for hash_table_two_probe: a directed table of operations,
// then weighted random traffic on both valid/ready channels, with every result beat
// checked against an internal model of the slot store. Depends on htp_pkg and the rtl.

module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import htp_pkg::*;

	localparam int TBL_SLOTS       = 64;
	localparam int N_DIR           = 25;
	localparam int RANDOM_BEATS    = 930;
	localparam int POOL_KEYS       = 40;
	localparam int PRESSURE_AT     = 500;
	localparam int PRESSURE_CYCLES = 400;
	localparam int DRAIN_CYCLES    = 100;

	// One operation beat and one result beat, at the port widths.
	typedef struct packed {
		mode_t             op;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
		logic [RANK_W-1:0] rank;
	} op_beat_t;

	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] slot;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
	} table_reply_t;

	// A directed row carries its reply only where it is obvious; otherwise the
	// table model supplies it.
	typedef struct packed {
		op_beat_t     beat;
		logic         typed;
		table_reply_t reply;
	} directed_row_t;

	localparam table_reply_t NO_HIT = '0;

	// Directed walk. Keys 1, 101, 201 and 301 share one primary slot (27), so the
	// rows exercise the fallback slot, a repeated key placed in its fallback slot
	// beside the older copy, lookup through the fallback after the primary is freed,
	// and misses on both probes. The first rows hit the empty table and key zero.
	localparam directed_row_t DIRECTED_ROWS [N_DIR] = '{
		'{'{MODE_LOOKUP, 16'd1,     32'h0000_0000, 7'd0},  1'b1, NO_HIT},
		'{'{MODE_DELETE, 16'd65535, 32'h0000_0000, 7'd0},  1'b1, NO_HIT},
		'{'{MODE_RANK,   16'd0,     32'h0000_0000, 7'd1},  1'b1, NO_HIT},
		'{'{MODE_RANK,   16'd0,     32'h0000_0000, 7'd0},  1'b1, NO_HIT},
		'{'{MODE_INSERT, 16'd0,     32'hffff_ffff, 7'd0},  1'b1, NO_HIT},
		'{'{MODE_LOOKUP, 16'd0,     32'h0000_0000, 7'd0},  1'b1, NO_HIT},
		'{'{MODE_DELETE, 16'd0,     32'h0000_0000, 7'd0},  1'b1, NO_HIT},
		'{'{MODE_INSERT, 16'd1,     32'hffff_ffff, 7'd0},  1'b1,
			'{1'b1, 6'd27, 16'd1, 32'hffff_ffff}},
		'{'{MODE_INSERT, 16'd65535, 32'h0000_0000, 7'd64}, 1'b1,
			'{1'b1, 6'd3, 16'd65535, 32'h0000_0000}},
		'{'{MODE_INSERT, 16'd101,   32'h1234_5678, 7'd0},  1'b0, NO_HIT},
		'{'{MODE_INSERT, 16'd201,   32'h8000_0001, 7'd0},  1'b0, NO_HIT},
		'{'{MODE_INSERT, 16'd1,     32'h5555_aaaa, 7'd0},  1'b0, NO_HIT},
		'{'{MODE_LOOKUP, 16'd101,   32'h0000_0000, 7'd0},  1'b0, NO_HIT},
		'{'{MODE_LOOKUP, 16'd1,     32'h0000_0000, 7'd0},  1'b0, NO_HIT},
		'{'{MODE_DELETE, 16'd1,     32'h0000_0000, 7'd0},  1'b0, NO_HIT},
		'{'{MODE_LOOKUP, 16'd1,     32'h0000_0000, 7'd0},  1'b0, NO_HIT},
		'{'{MODE_INSERT, 16'd301,   32'h0f0f_7e7e, 7'd0},  1'b0, NO_HIT},
		'{'{MODE_LOOKUP, 16'd201,   32'h0000_0000, 7'd0},  1'b0, NO_HIT},
		'{'{MODE_LOOKUP, 16'd401,   32'h0000_0000, 7'd0},  1'b0, NO_HIT},
		'{'{MODE_DELETE, 16'd201,   32'h0000_0000, 7'd0},  1'b0, NO_HIT},
		'{'{MODE_RANK,   16'd0,     32'h0000_0000, 7'd1},  1'b0, NO_HIT},
		'{'{MODE_RANK,   16'd0,     32'h0000_0000, 7'd2},  1'b0, NO_HIT},
		'{'{MODE_RANK,   16'd0,     32'h0000_0000, 7'd64}, 1'b1, NO_HIT},
		'{'{MODE_RANK,   16'd0,     32'h0000_0000, 7'd4},  1'b0, NO_HIT},
		'{'{MODE_RANK,   16'd0,     32'h0000_0000, 7'd5},  1'b1, NO_HIT}
	};

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_ready;
	logic [MODE_W-1:0] mode        = '0;
	logic [KEY_W-1:0]  key         = '0;
	logic [VAL_W-1:0]  value       = '0;
	logic [RANK_W-1:0] rank        = '0;
	logic              out_valid;
	logic              out_ready   = 1'b0;
	logic              found;
	logic [SLOT_W-1:0] slot;
	logic [KEY_W-1:0]  found_key;
	logic [VAL_W-1:0]  found_value;

	// Model of the slot store and the queue of replies still owed by the block.
	logic [KEY_W-1:0] slot_keys [TBL_SLOTS] = '{default: '0};
	logic [VAL_W-1:0] slot_vals [TBL_SLOTS] = '{default: '0};
	table_reply_t     pending_replies [$];
	int               error_count = 0;
	bit               quiet_run   = 1'b0;

	hash_table_two_probe i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.key         (key),
		.value       (value),
		.rank        (rank),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.found       (found),
		.slot        (slot),
		.found_key   (found_key),
		.found_value (found_value)
	);

	always #5ns clk = ~clk;

	// Reset starts asserted and is released once.
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Applies one operation to the model store and returns the reply it owes.
	function automatic table_reply_t apply_op(op_beat_t b);
		table_reply_t r;
		int unsigned  kv, home, alt, hit_slot, seen;
		bit           hit;
		r        = NO_HIT;
		hit      = 1'b0;
		hit_slot = 0;
		kv       = b.key;
		if (b.op == MODE_RANK) begin
			seen = 0;
			for (int i = 0; i < TBL_SLOTS; i++) begin
				if (slot_keys[i] != '0 && !hit) begin
					seen++;
					if (seen == b.rank) begin
						hit      = 1'b1;
						hit_slot = i;
					end
				end
			end
		end else if (kv != 0) begin
			home = ((43 * kv) % 100) * TBL_SLOTS / 100;
			alt  = (13 * kv) % TBL_SLOTS;
			if (b.op == MODE_INSERT) begin
				// A busy primary slot sends the key to the fallback slot, whatever it holds.
				hit_slot            = (slot_keys[home] == '0) ? home : alt;
				slot_keys[hit_slot] = b.key;
				slot_vals[hit_slot] = b.value;
				hit                 = 1'b1;
			end else if (slot_keys[home] == b.key) begin
				hit      = 1'b1;
				hit_slot = home;
			end else if (slot_keys[alt] == b.key) begin
				hit      = 1'b1;
				hit_slot = alt;
			end
		end
		if (hit) begin
			r.found = 1'b1;
			r.slot  = hit_slot[SLOT_W-1:0];
			r.key   = slot_keys[hit_slot];
			r.value = slot_vals[hit_slot];
			// A delete reports the entry as it was, then empties the slot.
			if (b.op == MODE_DELETE) begin
				slot_keys[hit_slot] = '0;
				slot_vals[hit_slot] = '0;
			end
		end
		return r;
	endfunction

	// Idle length for either side: mostly none or short, now and then long.
	function automatic int idle_len(bit quiet);
		int roll;
		roll = $urandom_range(0, 99);
		if (quiet || roll < 50) return 0;
		if (roll < 85) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Sender: directed rows first, then random traffic shaped in phases that
	// fill the table, mix operations, and drain it again.
	initial begin : sender
		op_beat_t     beat;
		table_reply_t reply;
		logic [KEY_W-1:0] key_pool [POOL_KEYS];
		int gap, roll, occupied, ins_pct, del_pct, idx, base;
		bit typed;
		// Key pool: random keys plus partners that differ by multiples of 100,
		// which land on the same primary slot.
		for (int i = 0; i < POOL_KEYS; i++) begin
			if (i < 24) begin
				key_pool[i] = KEY_W'($urandom_range(1, 65535));
			end else begin
				base = key_pool[i % 8];
				if (base > 32767) key_pool[i] = KEY_W'(base - 100 * $urandom_range(1, 300));
				else key_pool[i] = KEY_W'(base + 100 * $urandom_range(1, 300));
			end
		end
		wait (arst_n === 1'b1);
		@(posedge clk);
		for (int n = 0; n < N_DIR + RANDOM_BEATS; n++) begin
			idx       = n - N_DIR;
			quiet_run = (idx >= 300 && idx < 400);
			gap       = idle_len(quiet_run);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			typed = 1'b0;
			if (n < N_DIR) begin
				beat  = DIRECTED_ROWS[n].beat;
				typed = DIRECTED_ROWS[n].typed;
			end else begin
				if (idx < 300) begin
					ins_pct = 50;
					del_pct = 10;
				end else if (idx >= 550 && idx < 750) begin
					ins_pct = 15;
					del_pct = 45;
				end else begin
					ins_pct = 30;
					del_pct = 25;
				end
				roll = $urandom_range(0, 99);
				if (roll < ins_pct) beat.op = MODE_INSERT;
				else if (roll < ins_pct + del_pct) beat.op = MODE_DELETE;
				else if (roll < 85) beat.op = MODE_LOOKUP;
				else beat.op = MODE_RANK;
				roll = $urandom_range(0, 99);
				if (roll < 2) beat.key = '0;
				else if (roll < 75) beat.key = key_pool[$urandom_range(0, POOL_KEYS - 1)];
				else beat.key = KEY_W'($urandom_range(1, 65535));
				roll = $urandom_range(0, 99);
				if (roll < 5) beat.value = '1;
				else if (roll < 10) beat.value = '0;
				else beat.value = $urandom;
				// Ranks mostly fall among the occupied slots or just past them.
				occupied = 0;
				for (int i = 0; i < TBL_SLOTS; i++) begin
					if (slot_keys[i] != '0) occupied++;
				end
				if ($urandom_range(0, 99) < 85) begin
					beat.rank = RANK_W'($urandom_range(0, (occupied < 64) ? occupied + 1 : 64));
				end else begin
					beat.rank = RANK_W'($urandom_range(0, 64));
				end
			end
			in_valid <= 1'b1;
			mode     <= beat.op;
			key      <= beat.key;
			value    <= beat.value;
			rank     <= beat.rank;
			do @(posedge clk); while (in_ready !== 1'b1);
			reply = apply_op(beat);
			if (typed) reply = DIRECTED_ROWS[n].reply;
			pending_replies.push_back(reply);
		end
		in_valid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("hash_table_two_probe verification clean");
		end else begin
			$display("hash_table_two_probe verification failed");
		end
		$finish;
	end

	// Receiver: checks each result beat against the oldest owed reply and
	// stalls at random, once for a long stretch so the block backs up.
	initial begin : receiver
		table_reply_t got, want;
		int stall, hold_left, results_seen;
		stall        = 0;
		hold_left    = 0;
		results_seen = 0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready === 1'b1) begin
				got = {found, slot, found_key, found_value};
				if (pending_replies.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result beat, expected none,", $time,
						" got found=%0b slot=%0d key=%h value=%h",
						got.found, got.slot, got.key, got.value);
				end else begin
					want = pending_replies.pop_front();
					if (got !== want) begin
						error_count++;
						$display("%0t: result mismatch,", $time,
							" expected found=%0b slot=%0d key=%h value=%h,",
							want.found, want.slot, want.key, want.value,
							" got found=%0b slot=%0d key=%h value=%h",
							got.found, got.slot, got.key, got.value);
					end
				end
				results_seen++;
				if (results_seen == PRESSURE_AT) hold_left = PRESSURE_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else if (quiet_run || $urandom_range(0, 99) < 65) begin
				out_ready <= 1'b1;
			end else begin
				stall = idle_len(1'b0);
				out_ready <= 1'b0;
			end
		end
	end

	// Watchdog well beyond the slowest legal run.
	initial begin
		#8ms;
		$display("hash_table_two_probe verification failed");
		$finish;
	end

endmodule
